FILE: src/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants of the ultrasonic ranging scheduler
// field widths, register map codes, reset values and sensor interface structs
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

   localparam int DIST_W   = 17;
   localparam int CNT_W    = 16;
   localparam int TIME_W   = 32;
   localparam int MS_CFG_W = 16;
   localparam int CFG_AW   = 5;
   localparam int CFG_DW   = 32;

   // floor(w*17/10) == (w*DIST_MULT) >> DIST_SHIFT for any 16-bit w
   localparam int               DIST_SHIFT = 18;
   localparam int               MULT_W     = 19;
   localparam logic [MULT_W-1:0] DIST_MULT = 19'd445645;
   localparam int               PROD_W     = CNT_W + MULT_W;

   localparam logic [DIST_W-1:0]   MIN_DIST_RST     = 17'd200;
   localparam logic [DIST_W-1:0]   MAX_DIST_RST     = 17'd45000;
   localparam logic [DIST_W-1:0]   NO_ECHO_RST      = 17'd99900;
   localparam logic [MS_CFG_W-1:0] ECHO_TIMEOUT_RST = 16'd30;
   localparam logic [MS_CFG_W-1:0] TRIG_INTV_RST    = 16'd60;
   localparam logic [MS_CFG_W-1:0] STALE_RST        = 16'd500;

   // register index, taken from paddr[4:2]
   localparam logic [2:0] REG_MIN_DISTANCE   = 3'd0;
   localparam logic [2:0] REG_MAX_DISTANCE   = 3'd1;
   localparam logic [2:0] REG_NO_ECHO        = 3'd2;
   localparam logic [2:0] REG_ECHO_TIMEOUT   = 3'd3;
   localparam logic [2:0] REG_TRIG_INTERVAL  = 3'd4;
   localparam logic [2:0] REG_STALE          = 3'd5;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_EDGE = 1'b1;

   typedef struct packed {
      logic [DIST_W-1:0]   min_distance;
      logic [DIST_W-1:0]   max_distance;
      logic [DIST_W-1:0]   no_echo_distance;
      logic [MS_CFG_W-1:0] echo_timeout_ms;
      logic [MS_CFG_W-1:0] trigger_interval_ms;
      logic [MS_CFG_W-1:0] stale_ms;
   } urs_cfg_type;

   // per-sensor update request for one transaction
   typedef struct packed {
      logic              tick;
      logic              fire;
      logic              rise;
      logic              done;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] now;
      logic [DIST_W-1:0] distance;
   } urs_cmd_type;

   // per-sensor current edge state and post-update report values
   typedef struct packed {
      logic              echo_high;
      logic [CNT_W-1:0]  start_count;
      logic              timed_out;
      logic [DIST_W-1:0] distance_nx;
      logic              valid_nx;
      logic [TIME_W-1:0] last_good_nx;
   } urs_status_type;

endpackage

`default_nettype wire

FILE: src/urs_csr.sv
// ----------------------------------------------------------------------------
// urs_csr: configuration register file
// apb-style write and read access to the six ranging registers
// ----------------------------------------------------------------------------
`default_nettype none

module urs_csr import urs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CFG_AW-1:0] paddr,
   input  wire logic [CFG_DW-1:0] pwdata,
   output logic      [CFG_DW-1:0] prdata,
   output logic                   pready,
   output urs_cfg_type            cfg
);

   urs_cfg_type cfg_ff, cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx = paddr[CFG_AW-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MIN_DISTANCE:  cfg_in.min_distance        = pwdata[DIST_W-1:0];
            REG_MAX_DISTANCE:  cfg_in.max_distance        = pwdata[DIST_W-1:0];
            REG_NO_ECHO:       cfg_in.no_echo_distance    = pwdata[DIST_W-1:0];
            REG_ECHO_TIMEOUT:  cfg_in.echo_timeout_ms     = pwdata[MS_CFG_W-1:0];
            REG_TRIG_INTERVAL: cfg_in.trigger_interval_ms = pwdata[MS_CFG_W-1:0];
            REG_STALE:         cfg_in.stale_ms            = pwdata[MS_CFG_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_DISTANCE:  prdata = CFG_DW'(cfg_ff.min_distance);
         REG_MAX_DISTANCE:  prdata = CFG_DW'(cfg_ff.max_distance);
         REG_NO_ECHO:       prdata = CFG_DW'(cfg_ff.no_echo_distance);
         REG_ECHO_TIMEOUT:  prdata = CFG_DW'(cfg_ff.echo_timeout_ms);
         REG_TRIG_INTERVAL: prdata = CFG_DW'(cfg_ff.trigger_interval_ms);
         REG_STALE:         prdata = CFG_DW'(cfg_ff.stale_ms);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance        <= MIN_DIST_RST;
         cfg_ff.max_distance        <= MAX_DIST_RST;
         cfg_ff.no_echo_distance    <= NO_ECHO_RST;
         cfg_ff.echo_timeout_ms     <= ECHO_TIMEOUT_RST;
         cfg_ff.trigger_interval_ms <= TRIG_INTV_RST;
         cfg_ff.stale_ms            <= STALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/urs_dist.sv
// ----------------------------------------------------------------------------
// urs_dist: echo pulse width to distance
// floor(width*17/10) by reciprocal multiply, then min and max clamp
// ----------------------------------------------------------------------------
`default_nettype none

module urs_dist import urs_pkg::*; (
   input  wire logic [CNT_W-1:0]  width,
   input  wire logic [DIST_W-1:0] min_distance,
   input  wire logic [DIST_W-1:0] max_distance,
   output logic      [DIST_W-1:0] distance
);

   logic [PROD_W-1:0] product;
   logic [DIST_W-1:0] raw;
   logic [DIST_W-1:0] lo_clamped;

   assign product = PROD_W'(width) * PROD_W'(DIST_MULT);
   assign raw     = product[DIST_SHIFT +: DIST_W];

   // max clamp last so it wins over an inverted min
   assign lo_clamped = (raw < min_distance) ? min_distance : raw;
   assign distance   = (lo_clamped > max_distance) ? max_distance : lo_clamped;

endmodule

`default_nettype wire

FILE: src/urs_sensor.sv
// ----------------------------------------------------------------------------
// urs_sensor: state of one ranger
// timeout check, trigger start, echo edge capture and measurement commit
// ----------------------------------------------------------------------------
`default_nettype none

module urs_sensor import urs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [DIST_W-1:0]   no_echo_distance,
   input  wire logic [MS_CFG_W-1:0] echo_timeout_ms,
   input  wire urs_cmd_type         cmd,
   output urs_status_type           status
);

   logic              meas_ff, meas_in;
   logic              high_ff, high_in;
   logic [CNT_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0] trig_ff, trig_in;
   logic [TIME_W-1:0] good_ff, good_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              valid_ff, valid_in;
   logic [TIME_W-1:0] since_trig;
   logic              timed_out;

   assign since_trig = cmd.now - trig_ff;
   assign timed_out  = cmd.tick & meas_ff & (since_trig > TIME_W'(echo_timeout_ms));

   always_comb begin
      meas_in  = meas_ff;
      high_in  = high_ff;
      start_in = start_ff;
      trig_in  = trig_ff;
      good_in  = good_ff;
      dist_in  = dist_ff;
      valid_in = valid_ff;
      if (timed_out) begin
         meas_in  = 1'b0;
         high_in  = 1'b0;
         valid_in = 1'b0;
         dist_in  = no_echo_distance;
      end
      // trigger comes after the timeout check
      if (cmd.fire) begin
         meas_in = 1'b1;
         high_in = 1'b0;
         trig_in = cmd.now;
      end
      if (cmd.rise) begin
         start_in = cmd.count;
         high_in  = 1'b1;
      end
      if (cmd.done) begin
         dist_in  = cmd.distance;
         valid_in = 1'b1;
         good_in  = cmd.now;
         meas_in  = 1'b0;
         high_in  = 1'b0;
      end
   end

   assign status.echo_high    = high_ff;
   assign status.start_count  = start_ff;
   assign status.timed_out    = timed_out;
   assign status.distance_nx  = dist_in;
   assign status.valid_nx     = valid_in;
   assign status.last_good_nx = good_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_ff  <= 1'b0;
         high_ff  <= 1'b0;
         start_ff <= '0;
         trig_ff  <= '0;
         good_ff  <= '0;
         dist_ff  <= NO_ECHO_RST;
         valid_ff <= 1'b0;
      end else begin
         meas_ff  <= meas_in;
         high_ff  <= high_in;
         start_ff <= start_in;
         trig_ff  <= trig_in;
         good_ff  <= good_in;
         dist_ff  <= dist_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/ultrasonic_ranging_scheduler_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_scheduler_top: round-robin ultrasonic ranging controller
// path: an accepted request goes through the input reg, then the result reg, to rsp_valid
// throughput: one transaction per cycle while rsp_stall does not hold the result, set by the single update stage
// reset: synchronous, clears control and sensor state, registers to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranging_scheduler_top import urs_pkg::*; #(
   parameter int NUM_SENSORS = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,

   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire logic [1:0]        req_sensor,
   input  wire logic              req_edge_level,
   input  wire logic [15:0]       req_micro_count,
   input  wire logic [31:0]       req_now_ms,

   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_trigger_fired,
   output logic [1:0]             rsp_trigger_sensor,
   output logic [2:0]             rsp_timeout_mask,
   output logic                   rsp_echo_done,
   output logic [16:0]            rsp_report_distance,
   output logic                   rsp_report_fresh,
   output logic [31:0]            rsp_report_age_ms,

   // configuration port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CFG_AW-1:0] csr_paddr,
   input  wire logic [CFG_DW-1:0] csr_pwdata,
   output logic      [CFG_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   urs_cfg_type cfg;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic              type_ff;
   logic [1:0]        sel_ff;
   logic              level_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [TIME_W-1:0] now_ff;

   // round-robin scheduler state
   logic [TIME_W-1:0] last_trig_ff, last_trig_in;
   logic [IDX_W-1:0]  next_ff, next_in;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic              fired_ff, fired_in;
   logic [1:0]        fsens_ff, fsens_in;
   logic [2:0]        tmask_ff, tmask_in;
   logic              done_ff, done_in;
   logic [DIST_W-1:0] rdist_ff, rdist_in;
   logic              fresh_ff, fresh_in;
   logic [TIME_W-1:0] age_ff, age_in;

   logic              out_busy;
   logic              advance;
   logic              is_tick;
   logic              is_edge;
   logic              sel_ok;
   logic              fire;
   logic [IDX_W-1:0]  fire_idx;
   logic              high_sel;
   logic [CNT_W-1:0]  start_sel;
   logic [CNT_W-1:0]  pulse_width;
   logic [DIST_W-1:0] meas_dist;
   logic              edge_done;
   logic [NUM_SENSORS-1:0] tmask_all;
   logic [DIST_W-1:0] dist_sel;
   logic              valid_sel;
   logic [TIME_W-1:0] good_sel;
   logic [TIME_W-1:0] age_sel;

   urs_cmd_type    cmd    [NUM_SENSORS];
   urs_status_type status [NUM_SENSORS];

   urs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // ---------------------------------------------------------------------
   // handshake: the result register decouples the two sides, so a new
   // request is taken whenever the held result can move on this cycle
   // ---------------------------------------------------------------------
   assign out_busy  = rsp_vld_ff & rsp_stall;
   assign advance   = in_vld_ff & ~out_busy;
   assign req_stall = in_vld_ff & out_busy;

   assign in_vld_in  = req_stall ? in_vld_ff : req_valid;
   assign rsp_vld_in = out_busy ? rsp_vld_ff : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         type_ff  <= req_type;
         sel_ff   <= req_sensor;
         level_ff <= req_edge_level;
         count_ff <= req_micro_count;
         now_ff   <= req_now_ms;
      end
   end

   // ---------------------------------------------------------------------
   // decode of the transaction in the input register
   // ---------------------------------------------------------------------
   assign is_tick = (type_ff == REQ_TICK);
   assign is_edge = (type_ff == REQ_EDGE);
   assign sel_ok  = (int'(sel_ff) < NUM_SENSORS);

   // trigger: at least trigger_interval_ms since the last one, wrapping time
   assign fire     = is_tick &
                     ((now_ff - last_trig_ff) >= TIME_W'(cfg.trigger_interval_ms));
   assign fire_idx = (int'(next_ff) < NUM_SENSORS) ? next_ff : '0;

   always_comb begin
      last_trig_in = last_trig_ff;
      next_in      = next_ff;
      if (advance & fire) begin
         last_trig_in = now_ff;
         if ((int'(fire_idx) + 1) >= NUM_SENSORS) begin
            next_in = '0;
         end else begin
            next_in = IDX_W'(int'(fire_idx) + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_trig_ff <= '0;
         next_ff      <= '0;
      end else begin
         last_trig_ff <= last_trig_in;
         next_ff      <= next_in;
      end
   end

   // ---------------------------------------------------------------------
   // echo edge: pick the addressed sensor's capture state, one shared
   // width-to-distance converter serves all sensors
   // ---------------------------------------------------------------------
   always_comb begin
      high_sel  = 1'b0;
      start_sel = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (int'(sel_ff) == i) begin
            high_sel  = status[i].echo_high;
            start_sel = status[i].start_count;
         end
      end
   end

   assign pulse_width = count_ff - start_sel;   // wraps modulo 2^16
   assign edge_done   = is_edge & sel_ok & ~level_ff & high_sel;

   urs_dist u_dist (
      .width        (pulse_width),
      .min_distance (cfg.min_distance),
      .max_distance (cfg.max_distance),
      .distance     (meas_dist)
   );

   // ---------------------------------------------------------------------
   // per-sensor state, all checked in parallel on a tick
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_sensor
      assign cmd[g].tick     = advance & is_tick;
      assign cmd[g].fire     = advance & fire & (int'(fire_idx) == g);
      assign cmd[g].rise     = advance & is_edge & level_ff & (int'(sel_ff) == g);
      assign cmd[g].done     = advance & edge_done & (int'(sel_ff) == g);
      assign cmd[g].count    = count_ff;
      assign cmd[g].now      = now_ff;
      assign cmd[g].distance = meas_dist;

      assign tmask_all[g] = status[g].timed_out;

      urs_sensor u_sensor (
         .clock            (clock),
         .reset            (reset),
         .no_echo_distance (cfg.no_echo_distance),
         .echo_timeout_ms  (cfg.echo_timeout_ms),
         .cmd              (cmd[g]),
         .status           (status[g])
      );
   end

   // ---------------------------------------------------------------------
   // report of the selected sensor, taken after this transaction's update
   // ---------------------------------------------------------------------
   always_comb begin
      dist_sel  = cfg.no_echo_distance;
      valid_sel = 1'b0;
      good_sel  = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (int'(sel_ff) == i) begin
            dist_sel  = status[i].distance_nx;
            valid_sel = status[i].valid_nx;
            good_sel  = status[i].last_good_nx;
         end
      end
   end

   assign age_sel = now_ff - good_sel;

   always_comb begin
      fired_in = is_tick & fire;
      fsens_in = (is_tick & fire) ? 2'(fire_idx) : 2'd0;
      tmask_in = is_tick ? 3'(tmask_all) : 3'd0;
      done_in  = edge_done;
      if (sel_ok) begin
         rdist_in = dist_sel;
         age_in   = age_sel;
         fresh_in = valid_sel & (age_sel < TIME_W'(cfg.stale_ms));
      end else begin
         // no sensor addressed
         rdist_in = cfg.no_echo_distance;
         age_in   = '1;
         fresh_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fired_ff <= fired_in;
         fsens_ff <= fsens_in;
         tmask_ff <= tmask_in;
         done_ff  <= done_in;
         rdist_ff <= rdist_in;
         fresh_ff <= fresh_in;
         age_ff   <= age_in;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_trigger_fired   = fired_ff;
   assign rsp_trigger_sensor  = fsens_ff;
   assign rsp_timeout_mask    = tmask_ff;
   assign rsp_echo_done       = done_ff;
   assign rsp_report_distance = rdist_ff;
   assign rsp_report_fresh    = fresh_ff;
   assign rsp_report_age_ms   = age_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ultrasonic_ranging_scheduler_top
// a scripted run of transactions, some with hand-written results, then randomized echo
// sequences and noise under several register settings; every other result is compared
// against an in-bench ranging predictor while both channels idle and stall at random
// ----------------------------------------------------------------------------

module tb_top import urs_pkg::*; ();

   localparam int SENSORS     = 3;
   localparam int MAX_REPORTS = 10;

   // one request transaction as the bench sees it
   typedef struct packed {
      logic              kind;
      logic [1:0]        sensor;
      logic              level;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] now;
   } ranging_event_type;

   // one result transaction, fields in port order
   typedef struct packed {
      logic              fired;
      logic [1:0]        fired_idx;
      logic [2:0]        tmask;
      logic              done;
      logic [DIST_W-1:0] distance;
      logic              fresh;
      logic [TIME_W-1:0] age;
   } ranging_report_type;

   // scripted row: the event, and a hand-written result where one is given
   typedef struct packed {
      ranging_event_type  ev;
      logic               typed;
      ranging_report_type rep;
   } script_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request channel
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic              req_type        = REQ_TICK;
   logic [1:0]        req_sensor      = 2'd0;
   logic              req_edge_level  = 1'b0;
   logic [15:0]       req_micro_count = 16'd0;
   logic [31:0]       req_now_ms      = 32'd0;

   // result channel
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_trigger_fired;
   logic [1:0]        rsp_trigger_sensor;
   logic [2:0]        rsp_timeout_mask;
   logic              rsp_echo_done;
   logic [16:0]       rsp_report_distance;
   logic              rsp_report_fresh;
   logic [31:0]       rsp_report_age_ms;

   // register port
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CFG_AW-1:0] csr_paddr   = '0;
   logic [CFG_DW-1:0] csr_pwdata  = '0;
   logic [CFG_DW-1:0] csr_prdata;
   logic              csr_pready;

   ultrasonic_ranging_scheduler_top #(
      .NUM_SENSORS(SENSORS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_sensor          (req_sensor),
      .req_edge_level      (req_edge_level),
      .req_micro_count     (req_micro_count),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_trigger_fired   (rsp_trigger_fired),
      .rsp_trigger_sensor  (rsp_trigger_sensor),
      .rsp_timeout_mask    (rsp_timeout_mask),
      .rsp_echo_done       (rsp_echo_done),
      .rsp_report_distance (rsp_report_distance),
      .rsp_report_fresh    (rsp_report_fresh),
      .rsp_report_age_ms   (rsp_report_age_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // predictor copy of the register file
   logic [DIST_W-1:0]   cfg_min_dist;
   logic [DIST_W-1:0]   cfg_max_dist;
   logic [DIST_W-1:0]   cfg_no_echo;
   logic [MS_CFG_W-1:0] cfg_timeout;
   logic [MS_CFG_W-1:0] cfg_interval;
   logic [MS_CFG_W-1:0] cfg_stale;

   // predictor copy of the per-sensor and scheduler state
   logic                sn_measuring [SENSORS];
   logic                sn_echo_high [SENSORS];
   logic [CNT_W-1:0]    sn_start     [SENSORS];
   logic [TIME_W-1:0]   sn_trig_time [SENSORS];
   logic [TIME_W-1:0]   sn_good_time [SENSORS];
   logic [DIST_W-1:0]   sn_distance  [SENSORS];
   logic                sn_valid     [SENSORS];
   logic [TIME_W-1:0]   last_trig;
   int                  next_idx;

   // results still owed by the block, oldest first
   ranging_report_type expected_reports [$];

   // hand-written result riding along with the transaction being offered
   logic               drive_typed  = 1'b0;
   ranging_report_type drive_report = '0;

   // millisecond time carried across random transactions
   logic [TIME_W-1:0] sim_now = '0;

   int  mismatches = 0;
   logic calm      = 1'b0;
   int  calm_left  = 0;
   int  stall_left = 0;

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         flag($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
      end
   endtask

   // works out one result and advances the predicted state
   task automatic predict_ranging(input ranging_event_type ev,
                                  output ranging_report_type rep);
      int                i;
      int                k;
      logic [TIME_W-1:0] elapsed;
      logic [CNT_W-1:0]  width;
      logic [31:0]       d;
      rep = '0;
      if (ev.kind == REQ_TICK) begin
         // late echoes are dropped before the scheduler looks at the interval
         for (i = 0; i < SENSORS; i++) begin
            elapsed = ev.now - sn_trig_time[i];
            if (sn_measuring[i] && elapsed > {16'd0, cfg_timeout}) begin
               sn_measuring[i] = 1'b0;
               sn_echo_high[i] = 1'b0;
               sn_valid[i]     = 1'b0;
               sn_distance[i]  = cfg_no_echo;
               rep.tmask[i]    = 1'b1;
            end
         end
         elapsed = ev.now - last_trig;
         if (elapsed >= {16'd0, cfg_interval}) begin
            k = (next_idx < SENSORS) ? next_idx : 0;
            last_trig       = ev.now;
            sn_measuring[k] = 1'b1;
            sn_echo_high[k] = 1'b0;
            sn_trig_time[k] = ev.now;
            rep.fired       = 1'b1;
            rep.fired_idx   = k[1:0];
            next_idx        = (k + 1 >= SENSORS) ? 0 : k + 1;
         end
      end else if (ev.sensor < SENSORS) begin
         if (ev.level) begin
            sn_start[ev.sensor]     = ev.count;
            sn_echo_high[ev.sensor] = 1'b1;
         end else if (sn_echo_high[ev.sensor]) begin
            width = ev.count - sn_start[ev.sensor];
            d = 32'(width) * 32'd17 / 32'd10;
            if (d < 32'(cfg_min_dist)) d = 32'(cfg_min_dist);
            if (d > 32'(cfg_max_dist)) d = 32'(cfg_max_dist);
            sn_distance[ev.sensor]  = d[DIST_W-1:0];
            sn_valid[ev.sensor]     = 1'b1;
            sn_good_time[ev.sensor] = ev.now;
            sn_measuring[ev.sensor] = 1'b0;
            sn_echo_high[ev.sensor] = 1'b0;
            rep.done = 1'b1;
         end
      end
      if (ev.sensor < SENSORS) begin
         rep.distance = sn_distance[ev.sensor];
         rep.age      = ev.now - sn_good_time[ev.sensor];
         rep.fresh    = sn_valid[ev.sensor] && (rep.age < {16'd0, cfg_stale});
      end else begin
         rep.distance = cfg_no_echo;
         rep.age      = '1;
         rep.fresh    = 1'b0;
      end
   endtask

   // mostly back to back, sometimes a short pause, now and then a long one
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // stretches where neither side idles
   always @(negedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(40, 200);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // result-side backpressure
   always @(negedge clock) begin : stall_drive
      int len;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         len = pick_gap();
         if (len > 0) begin
            stall_left <= len - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall  <= 1'b0;
         end
      end
   end

   // scoreboard: check results, then predict the transaction accepted at this edge
   always @(posedge clock) begin : watch
      ranging_report_type got;
      ranging_report_type want;
      ranging_report_type calc;
      ranging_event_type  ev;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_trigger_fired, rsp_trigger_sensor, rsp_timeout_mask, rsp_echo_done,
                   rsp_report_distance, rsp_report_fresh, rsp_report_age_ms};
            if (expected_reports.size() == 0) begin
               flag("result transaction with nothing expected");
            end else begin
               want = expected_reports.pop_front();
               compare_field("trigger_fired", want.fired, got.fired);
               compare_field("trigger_sensor", want.fired_idx, got.fired_idx);
               compare_field("timeout_mask", want.tmask, got.tmask);
               compare_field("echo_done", want.done, got.done);
               compare_field("report_distance", want.distance, got.distance);
               compare_field("report_fresh", want.fresh, got.fresh);
               compare_field("report_age_ms", want.age, got.age);
            end
         end
         if (req_valid && !req_stall) begin
            ev = {req_type, req_sensor, req_edge_level, req_micro_count, req_now_ms};
            predict_ranging(ev, calc);
            // scripted rows with a written-out answer are held to that answer
            expected_reports.push_back(drive_typed ? drive_report : calc);
         end
      end
   end

   // offer one transaction at a falling edge, return at a falling edge
   task automatic send(input ranging_event_type ev, input logic typed,
                       input ranging_report_type rep);
      int gap;
      req_valid       <= 1'b1;
      req_type        <= ev.kind;
      req_sensor      <= ev.sensor;
      req_edge_level  <= ev.level;
      req_micro_count <= ev.count;
      req_now_ms      <= ev.now;
      drive_typed     <= typed;
      drive_report    <= rep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // build a random transaction, mostly complete echo sequences
   task automatic make_random_event(output ranging_event_type ev);
      int unsigned r;
      int unsigned pick;
      int unsigned span;
      int          k;
      int          idx;
      logic        found;
      ev.kind   = REQ_EDGE;
      ev.sensor = 2'($urandom_range(0, SENSORS - 1));
      ev.level  = 1'($urandom_range(0, 1));
      ev.count  = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) begin
         // tick, time steps scaled to the current interval and timeout, now and then a jump
         ev.kind = REQ_TICK;
         if ($urandom_range(0, 9) == 0) ev.sensor = 2'd3;
         span = ((cfg_interval > cfg_timeout) ? cfg_interval : cfg_timeout) + 2;
         pick = $urandom_range(0, 99);
         if (pick < 15) sim_now += $urandom_range(0, 2);
         else if (pick < 92) sim_now += $urandom_range(0, 2 * span);
         else sim_now = $urandom;
      end else if (r < 85) begin
         // well-formed echo: favor a sensor that is waiting on its pulse
         found = 1'b0;
         if ($urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, SENSORS - 1);
            for (k = 0; k < SENSORS; k++) begin
               idx = (pick + k) % SENSORS;
               if (sn_measuring[idx] && !found) begin
                  ev.sensor = idx[1:0];
                  found     = 1'b1;
               end
            end
         end
         if (!sn_echo_high[ev.sensor]) begin
            ev.level = 1'b1;
         end else begin
            ev.level = 1'b0;
            if ($urandom_range(0, 4) == 0) ev.count = sn_start[ev.sensor] + 16'($urandom);
            else ev.count = sn_start[ev.sensor] + 16'($urandom_range(100, 27000));
         end
         sim_now += $urandom_range(0, 3);
      end else begin
         // noise: stray edges, unused sensor, time jumps
         ev.kind   = ($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_EDGE;
         ev.sensor = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) sim_now = $urandom;
         else sim_now += $urandom_range(0, 5);
      end
      ev.now = sim_now;
   endtask

   task automatic run_random(input int count);
      ranging_event_type ev;
      int                n;
      for (n = 0; n < count; n++) begin
         make_random_event(ev);
         send(ev, 1'b0, '0);
      end
   endtask

   // wait out every result still owed, then idle before returning
   task automatic drain();
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // register write: setup phase, access phase, then an idle phase with the select dropped
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MIN_DISTANCE:  cfg_min_dist = data[DIST_W-1:0];
         REG_MAX_DISTANCE:  cfg_max_dist = data[DIST_W-1:0];
         REG_NO_ECHO:       cfg_no_echo  = data[DIST_W-1:0];
         REG_ECHO_TIMEOUT:  cfg_timeout  = data[MS_CFG_W-1:0];
         REG_TRIG_INTERVAL: cfg_interval = data[MS_CFG_W-1:0];
         REG_STALE:         cfg_stale    = data[MS_CFG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // read every register back and compare its implemented bits
   task automatic verify_csrs();
      int          r;
      logic [2:0]  idx;
      logic [31:0] want;
      logic [31:0] mask;
      for (r = 0; r <= REG_STALE; r++) begin
         idx = r[2:0];
         case (idx)
            REG_MIN_DISTANCE:  want = 32'(cfg_min_dist);
            REG_MAX_DISTANCE:  want = 32'(cfg_max_dist);
            REG_NO_ECHO:       want = 32'(cfg_no_echo);
            REG_ECHO_TIMEOUT:  want = 32'(cfg_timeout);
            REG_TRIG_INTERVAL: want = 32'(cfg_interval);
            default:           want = 32'(cfg_stale);
         endcase
         mask = (idx <= REG_NO_ECHO) ? 32'h0001_FFFF : 32'h0000_FFFF;
         csr_psel    <= 1'b1;
         csr_pwrite  <= 1'b0;
         csr_penable <= 1'b0;
         csr_paddr   <= {idx, 2'b00};
         @(negedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         compare_field($sformatf("register %0d readback", r), want, csr_prdata & mask);
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(negedge clock);
      end
   endtask

   // registers only change once the block has gone quiet
   task automatic apply_settings(input logic [31:0] v_min, input logic [31:0] v_max,
                                 input logic [31:0] v_no_echo, input logic [31:0] v_timeout,
                                 input logic [31:0] v_interval, input logic [31:0] v_stale);
      req_valid <= 1'b0;
      drain();
      csr_write(REG_MIN_DISTANCE, v_min);
      csr_write(REG_MAX_DISTANCE, v_max);
      csr_write(REG_NO_ECHO, v_no_echo);
      csr_write(REG_ECHO_TIMEOUT, v_timeout);
      csr_write(REG_TRIG_INTERVAL, v_interval);
      csr_write(REG_STALE, v_stale);
      verify_csrs();
   endtask

   initial begin : stimulus
      script_row_type script [0:22];
      int             n;
      int             i;

      // predictor starts from the reset state
      cfg_min_dist = MIN_DIST_RST;
      cfg_max_dist = MAX_DIST_RST;
      cfg_no_echo  = NO_ECHO_RST;
      cfg_timeout  = ECHO_TIMEOUT_RST;
      cfg_interval = TRIG_INTV_RST;
      cfg_stale    = STALE_RST;
      for (i = 0; i < SENSORS; i++) begin
         sn_measuring[i] = 1'b0;
         sn_echo_high[i] = 1'b0;
         sn_start[i]     = '0;
         sn_trig_time[i] = '0;
         sn_good_time[i] = '0;
         sn_distance[i]  = NO_ECHO_RST;
         sn_valid[i]     = 1'b0;
      end
      last_trig = '0;
      next_idx  = 0;

      // scripted walk through the scheduler under reset settings
      script = '{
         // first tick lands before the interval has run out
         '{'{REQ_TICK, 2'd1, 1'b0, 16'h0000, 32'd0}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b0, NO_ECHO_RST, 1'b0, 32'd0}},
         // edge on the unused sensor is ignored, age reads all ones
         '{'{REQ_EDGE, 2'd3, 1'b1, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b0, NO_ECHO_RST, 1'b0, 32'hFFFF_FFFF}},
         // falling edge with no rising edge before it
         '{'{REQ_EDGE, 2'd0, 1'b0, 16'h0000, 32'd100}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b0, NO_ECHO_RST, 1'b0, 32'd100}},
         // interval reached exactly, sensor 0 fires
         '{'{REQ_TICK, 2'd0, 1'b0, 16'h0000, 32'd60}, 1'b1,
           '{1'b1, 2'd0, 3'b000, 1'b0, NO_ECHO_RST, 1'b0, 32'd60}},
         '{'{REQ_EDGE, 2'd0, 1'b1, 16'hFFF0, 32'd61}, 1'b0, '0},
         // count wraps, short pulse clamps up to the minimum
         '{'{REQ_EDGE, 2'd0, 1'b0, 16'h0010, 32'd62}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b1, MIN_DIST_RST, 1'b1, 32'd0}},
         '{'{REQ_TICK, 2'd0, 1'b0, 16'h0000, 32'd121}, 1'b0, '0},
         // sensor 1 misses its echo by one millisecond
         '{'{REQ_TICK, 2'd1, 1'b0, 16'h0000, 32'd152}, 1'b1,
           '{1'b0, 2'd0, 3'b010, 1'b0, NO_ECHO_RST, 1'b0, 32'd152}},
         '{'{REQ_TICK, 2'd2, 1'b0, 16'h0000, 32'd181}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd2, 1'b1, 16'h0000, 32'd182}, 1'b0, '0},
         // second rising edge overwrites the start count
         '{'{REQ_EDGE, 2'd2, 1'b1, 16'd100, 32'd183}, 1'b0, '0},
         // widest pulse clamps down to the maximum
         '{'{REQ_EDGE, 2'd2, 1'b0, 16'd99, 32'd184}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b1, MAX_DIST_RST, 1'b1, 32'd0}},
         // rising edge on a sensor that is not measuring still counts
         '{'{REQ_EDGE, 2'd1, 1'b1, 16'd5, 32'd185}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd1, 1'b0, 16'd1005, 32'd186}, 1'b0, '0},
         // age just under the stale limit, then at it
         '{'{REQ_TICK, 2'd0, 1'b0, 16'h0000, 32'd561}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd0, 1'b0, 16'h0000, 32'd562}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd0, 1'b1, 16'h0000, 32'd563}, 1'b0, '0},
         // timeout while the echo is high, report on the unused sensor
         '{'{REQ_TICK, 2'd3, 1'b0, 16'h0000, 32'd594}, 1'b1,
           '{1'b0, 2'd0, 3'b001, 1'b0, NO_ECHO_RST, 1'b0, 32'hFFFF_FFFF}},
         // millisecond time wraps through zero
         '{'{REQ_TICK, 2'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFF0}, 1'b0, '0},
         '{'{REQ_TICK, 2'd1, 1'b0, 16'h0000, 32'd5}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd1, 1'b1, 16'h8000, 32'd6}, 1'b0, '0},
         // zero-width pulse
         '{'{REQ_EDGE, 2'd1, 1'b0, 16'h8000, 32'd7}, 1'b0, '0},
         '{'{REQ_EDGE, 2'd3, 1'b0, 16'hFFFF, 32'd8}, 1'b1,
           '{1'b0, 2'd0, 3'b000, 1'b0, NO_ECHO_RST, 1'b0, 32'hFFFF_FFFF}}
      };
      sim_now = 32'd8;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      verify_csrs();

      for (n = 0; n <= 22; n++) begin
         send(script[n].ev, script[n].typed, script[n].rep);
      end
      run_random(100);

      // low extremes, widest clamp window, every tick fires
      apply_settings(32'd0, 32'h1_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
      run_random(100);

      // high extremes, minimum above maximum
      apply_settings(32'h1_FFFF, 32'd1000, 32'h1_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
      run_random(100);

      // plausible field settings
      apply_settings($urandom_range(0, 2000), $urandom_range(20000, 131071),
                     $urandom_range(0, 131071), $urandom_range(1, 100),
                     $urandom_range(1, 150), $urandom_range(50, 2000));
      run_random(100);

      // raw 32-bit writes, upper bits must be dropped
      apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(100);

      req_valid <= 1'b0;
      drain();
      if (mismatches == 0) begin
         $display("ultrasonic_ranging_scheduler_top verification clean");
      end else begin
         $display("ultrasonic_ranging_scheduler_top verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("ultrasonic_ranging_scheduler_top verification failed");
      $finish;
   end

endmodule
